// ----- design/free_block_list_allocator_unit_macros.svh -----
// assertion macros for the free block list allocator
// used by free_block_list_allocator_unit; expects clk and rst_n in scope
`ifndef FREE_BLOCK_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define FREE_BLOCK_LIST_ALLOCATOR_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, off during reset
`define FBLA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fbla assertion failed");

// next-cycle implication, off during reset
`define FBLA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fbla assertion failed");

`else

`define FBLA_ASSERT_IMP(lbl, ante, cons)
`define FBLA_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- design/fbla_pkg.sv -----
// package for the free block list allocator: request and result types, codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fbla_pkg;

  localparam int LIST_SIZE_DEF = 100;
  localparam int WORD_W        = 16;

  // action codes
  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_REL   = 2'd1;
  localparam logic [1:0] ACT_XFER  = 2'd2;

  // status codes
  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_NOSPACE  = 3'd1;
  localparam logic [2:0] ST_BADCOUNT = 3'd2;
  localparam logic [2:0] ST_REFILL   = 3'd3;
  localparam logic [2:0] ST_SPILL    = 3'd4;
  localparam logic [2:0] ST_BUSY     = 3'd5;
  localparam logic [2:0] ST_WORD     = 3'd6;
  localparam logic [2:0] ST_NOXFER   = 3'd7;

  typedef struct packed {
    logic [1:0]        action;
    logic [WORD_W-1:0] block_number;
    logic [WORD_W-1:0] fill_word;
  } in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [WORD_W-1:0] result_block;
    logic [WORD_W-1:0] spill_word;
    logic              last_word;
    logic [WORD_W-1:0] free_count;
  } out_t;

endpackage

`default_nettype wire

// ----- design/fbla_ram.sv -----
// single-port-write, single-port-read stack memory with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module fbla_ram #(
  parameter int DEPTH = 100,
  parameter int AW    = 7,
  parameter int DW    = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/free_block_list_allocator_unit.sv -----
// Free block list allocator: a stack of up to LIST_SIZE free block numbers held
// in a synchronous RAM, with allocate, release and list-word transfer requests.
// Each request passes an accept state, which issues the stack RAM read, and a
// read state, which applies the update and loads the result register. The read
// state waits while an earlier result is still held by the consumer; no new
// request is accepted until the current one is applied. After reset the block is
// in refill mode and expects LIST_SIZE+1 transfer words; no clearing pass runs.
// Depends on fbla_pkg, fbla_ram and free_block_list_allocator_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "free_block_list_allocator_unit_macros.svh"

module free_block_list_allocator_unit #(
  parameter int LIST_SIZE = fbla_pkg::LIST_SIZE_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire fbla_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output fbla_pkg::out_t     out_data
);

  localparam int AW = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;
  localparam int WW = $clog2(LIST_SIZE + 1);
  localparam int DW = fbla_pkg::WORD_W;

  typedef enum logic {S_ACC, S_RD} state_t;
  typedef enum logic [1:0] {M_IDLE, M_REFILL, M_SPILL} mode_t;

  state_t              st_r, st_nxt;
  mode_t               mode_r, mode_nxt;
  logic [WW-1:0]       widx_r, widx_nxt;
  logic [DW-1:0]       count_r, count_nxt;
  logic [DW-1:0]       pend_r, pend_nxt;
  fbla_pkg::in_t       item_r;
  fbla_pkg::out_t      out_r, res;
  logic                out_valid_r, out_valid_nxt;

  logic                in_fire, apply;
  logic [AW-1:0]       raddr, waddr;
  logic [DW-1:0]       wdata, rdata;
  logic                we;
  logic [DW-1:0]       top;
  logic [WW-1:0]       widx_m1;
  logic                last;

  assign in_ready  = (st_r == S_ACC);
  assign in_fire   = in_valid && in_ready;
  assign apply     = (st_r == S_RD) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign top     = count_r - DW'(1);
  assign widx_m1 = widx_r - WW'(1);
  assign last    = (widx_r >= WW'(LIST_SIZE));

  // read address: top of stack for allocate, next entry for a spill word
  always_comb begin
    if (in_data.action == fbla_pkg::ACT_ALLOC) begin
      raddr = top[AW-1:0];
    end else begin
      raddr = widx_m1[AW-1:0];
    end
  end

  // stack memory; writes land in the apply cycle, before the next read is issued
  fbla_ram #(
    .DEPTH (LIST_SIZE),
    .AW    (AW),
    .DW    (DW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (in_fire),
    .raddr (raddr),
    .rdata (rdata)
  );

  // request decode and state update
  always_comb begin
    mode_nxt  = mode_r;
    widx_nxt  = widx_r;
    count_nxt = count_r;
    pend_nxt  = pend_r;
    we        = 1'b0;
    waddr     = widx_m1[AW-1:0];
    wdata     = item_r.fill_word;
    res.status       = fbla_pkg::ST_NOXFER;
    res.result_block = '0;
    res.spill_word   = '0;
    res.last_word    = 1'b0;
    case (item_r.action)
      fbla_pkg::ACT_XFER: begin
        if (mode_r == M_REFILL) begin
          if (widx_r == '0) begin
            count_nxt = item_r.fill_word;
          end else begin
            we = 1'b1;
          end
          widx_nxt = widx_r + WW'(1);
          if (last) begin
            mode_nxt = M_IDLE;
            widx_nxt = '0;
          end
          res.status       = fbla_pkg::ST_WORD;
          res.result_block = pend_r;
          res.last_word    = last;
        end else if (mode_r == M_SPILL) begin
          res.spill_word = (widx_r == '0) ? count_r : rdata;
          widx_nxt = widx_r + WW'(1);
          if (last) begin
            we        = 1'b1;
            waddr     = '0;
            wdata     = pend_r;
            count_nxt = DW'(1);
            mode_nxt  = M_IDLE;
            widx_nxt  = '0;
          end
          res.status       = fbla_pkg::ST_WORD;
          res.result_block = pend_r;
          res.last_word    = last;
        end
      end
      fbla_pkg::ACT_ALLOC: begin
        if (mode_r != M_IDLE) begin
          res.status = fbla_pkg::ST_BUSY;
        end else if (count_r == '0 || count_r > DW'(LIST_SIZE)) begin
          res.status = fbla_pkg::ST_BADCOUNT;
        end else begin
          count_nxt = top;
          if (rdata == '0) begin
            res.status = fbla_pkg::ST_NOSPACE;
          end else if (top == '0) begin
            // last entry taken: host refills from the returned block
            mode_nxt         = M_REFILL;
            widx_nxt         = '0;
            pend_nxt         = rdata;
            res.status       = fbla_pkg::ST_REFILL;
            res.result_block = rdata;
          end else begin
            res.status       = fbla_pkg::ST_DONE;
            res.result_block = rdata;
          end
        end
      end
      fbla_pkg::ACT_REL: begin
        if (mode_r != M_IDLE) begin
          res.status = fbla_pkg::ST_BUSY;
        end else if (count_r >= DW'(LIST_SIZE)) begin
          // full stack: spill into the released block
          mode_nxt         = M_SPILL;
          widx_nxt         = '0;
          pend_nxt         = item_r.block_number;
          res.status       = fbla_pkg::ST_SPILL;
          res.result_block = item_r.block_number;
        end else begin
          we         = 1'b1;
          waddr      = count_r[AW-1:0];
          wdata      = item_r.block_number;
          count_nxt  = count_r + DW'(1);
          res.status = fbla_pkg::ST_DONE;
        end
      end
      default: begin
        res.status = fbla_pkg::ST_NOXFER;
      end
    endcase
    res.free_count = count_nxt;
    if (!apply) begin
      we = 1'b0;
    end
  end

  // sequencer next state and output valid
  always_comb begin
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (st_r)
      S_ACC: begin
        if (in_fire) begin
          st_nxt = S_RD;
        end
      end
      S_RD: begin
        if (apply) begin
          st_nxt        = S_ACC;
          out_valid_nxt = 1'b1;
        end
      end
      default: st_nxt = S_ACC;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_ACC;
      mode_r      <= M_REFILL;
      widx_r      <= '0;
      count_r     <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      if (apply) begin
        mode_r  <= mode_nxt;
        widx_r  <= widx_nxt;
        count_r <= count_nxt;
        pend_r  <= pend_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_data;
    end
    if (apply) begin
      out_r <= res;
    end
  end

  // checks
  `FBLA_ASSERT_NXT(a_busy_after_accept, in_fire, !in_ready)
  `FBLA_ASSERT_IMP(a_idle_index_zero, mode_r == M_IDLE, widx_r == '0)
  `FBLA_ASSERT_IMP(a_last_only_on_word, out_valid_r && out_r.last_word,
                   out_r.status == fbla_pkg::ST_WORD)

endmodule

`default_nettype wire
